// ===== src/qs_pkg.sv =====
// Shared sizes and types for the quicksort engine.
package qs_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int DATA_W       = 32;
    localparam int ADDR_W       = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CNT_W        = ADDR_W + 1;
    localparam int STACK_DEPTH  = MAX_ELEMENTS;
    localparam int STACK_AW     = ADDR_W;
    localparam int SP_W         = STACK_AW + 1;

    // One pending range on the stack, both ends inclusive.
    typedef struct packed {
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
    } range_t;

endpackage

// ===== src/quicksort_engine.sv =====
// Quicksort engine: collects up to MAX_ELEMENTS signed words, sorts them in place and streams
// them out in ascending order. Loading takes one word per cycle while in_stall is low. The
// word marked last_item starts the sort; in_stall then stays high until the final sorted word
// has been taken. The sort runs on one single-port-read element memory: each scan step is
// a read, then a compare and move, and each partition adds a stack pop, pivot fetch, pivot
// placement and range pushes. Emission then reads one word at a time, fetching the next word
// while the current one leaves, and holds each word through any output stall. Words arriving
// with the store full are dropped and every result of that set carries overflowed.
module quicksort_engine (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [qs_pkg::DATA_W-1:0] value,
    input  logic                             last_item,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [qs_pkg::DATA_W-1:0] sorted_value,
    output logic                             last_result,
    output logic                             overflowed
);
    import qs_pkg::*;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_POP,
        ST_POP_WAIT,
        ST_PIVOT,
        ST_RIGHT_RD,
        ST_RIGHT_CMP,
        ST_LEFT_RD,
        ST_LEFT_CMP,
        ST_PLACE,
        ST_PUSH_HI,
        ST_EMIT_RD,
        ST_EMIT_WAIT,
        ST_EMIT_HOLD
    } state_t;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      ovf_reg, ovf_next;
    logic [SP_W-1:0]           sp_reg, sp_next;
    logic [ADDR_W-1:0]         lo_reg, lo_next;
    logic [ADDR_W-1:0]         hi_reg, hi_next;
    logic [ADDR_W-1:0]         l_reg, l_next;
    logic [ADDR_W-1:0]         h_reg, h_next;
    logic [ADDR_W-1:0]         k_reg, k_next;
    logic signed [DATA_W-1:0]  pivot_reg, pivot_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0]  out_value_reg, out_value_next;
    logic                      out_last_reg, out_last_next;
    logic                      out_ovf_reg, out_ovf_next;

    // element store
    logic signed [DATA_W-1:0]  store_mem [MAX_ELEMENTS];
    logic signed [DATA_W-1:0]  store_rdata_reg;
    logic                      st_we;
    logic [ADDR_W-1:0]         st_waddr;
    logic signed [DATA_W-1:0]  st_wdata;
    logic [ADDR_W-1:0]         st_raddr;

    // range stack
    range_t                    stack_mem [STACK_DEPTH];
    range_t                    stack_rdata_reg;
    logic                      stk_we;
    logic [STACK_AW-1:0]       stk_waddr;
    range_t                    stk_wdata;
    logic [STACK_AW-1:0]       stk_raddr;

    logic                      store_room;
    logic [CNT_W-1:0]          load_cnt;
    logic [CNT_W-1:0]          load_top;
    logic                      stack_room;
    logic [SP_W-1:0]           sp_dec;
    logic [SP_W-1:0]           sp_inc;
    logic                      push_lo_ok;
    logic                      push_hi_ok;
    logic                      emit_last;

    assign store_room = count_reg < CNT_W'(MAX_ELEMENTS);
    assign load_cnt   = store_room ? count_reg + CNT_W'(1) : count_reg;
    assign load_top   = load_cnt - CNT_W'(1);
    assign stack_room = sp_reg < SP_W'(STACK_DEPTH);
    assign sp_dec     = sp_reg - SP_W'(1);
    assign sp_inc     = sp_reg + SP_W'(1);
    // left part lo..l-1 has two or more words when lo+1 < l
    assign push_lo_ok = (CNT_W'(lo_reg) + CNT_W'(1) < CNT_W'(l_reg)) && stack_room;
    assign push_hi_ok = (CNT_W'(l_reg) + CNT_W'(1) < CNT_W'(hi_reg)) && stack_room;
    assign emit_last  = (CNT_W'(k_reg) + CNT_W'(1)) == count_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        sp_next        = sp_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        l_next         = l_reg;
        h_next         = h_reg;
        k_next         = k_reg;
        pivot_next     = pivot_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        st_we          = 1'b0;
        st_waddr       = l_reg;
        st_wdata       = pivot_reg;
        st_raddr       = h_reg;
        stk_we         = 1'b0;
        stk_waddr      = sp_reg[STACK_AW-1:0];
        stk_wdata      = '{lo: lo_reg, hi: hi_reg};
        stk_raddr      = sp_dec[STACK_AW-1:0];

        case (state_reg)
            ST_LOAD:
            begin
                if (in_valid)
                begin
                    if (store_room)
                    begin
                        st_we    = 1'b1;
                        st_waddr = count_reg[ADDR_W-1:0];
                        st_wdata = value;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    count_next = load_cnt;
                    if (last_item)
                    begin
                        if (load_cnt >= CNT_W'(2))
                        begin
                            stk_we     = 1'b1;
                            stk_waddr  = '0;
                            stk_wdata  = '{lo: '0, hi: load_top[ADDR_W-1:0]};
                            sp_next    = SP_W'(1);
                            state_next = ST_POP;
                        end
                        else
                        begin
                            k_next     = '0;
                            state_next = ST_EMIT_RD;
                        end
                    end
                end
            end
            ST_POP:
            begin
                stk_raddr  = sp_dec[STACK_AW-1:0];
                sp_next    = sp_dec;
                state_next = ST_POP_WAIT;
            end
            ST_POP_WAIT:
            begin
                lo_next    = stack_rdata_reg.lo;
                hi_next    = stack_rdata_reg.hi;
                l_next     = stack_rdata_reg.lo;
                h_next     = stack_rdata_reg.hi;
                st_raddr   = stack_rdata_reg.lo;
                state_next = ST_PIVOT;
            end
            ST_PIVOT:
            begin
                pivot_next = store_rdata_reg;
                state_next = ST_RIGHT_RD;
            end
            ST_RIGHT_RD:
            begin
                if (l_reg < h_reg)
                begin
                    st_raddr   = h_reg;
                    state_next = ST_RIGHT_CMP;
                end
                else
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_RIGHT_CMP:
            begin
                if (store_rdata_reg >= pivot_reg)
                begin
                    h_next     = h_reg - ADDR_W'(1);
                    state_next = ST_RIGHT_RD;
                end
                else
                begin
                    // fill the hole at the left scan
                    st_we      = 1'b1;
                    st_waddr   = l_reg;
                    st_wdata   = store_rdata_reg;
                    state_next = ST_LEFT_RD;
                end
            end
            ST_LEFT_RD:
            begin
                if (l_reg < h_reg)
                begin
                    st_raddr   = l_reg;
                    state_next = ST_LEFT_CMP;
                end
                else
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_LEFT_CMP:
            begin
                if (store_rdata_reg <= pivot_reg)
                begin
                    l_next     = l_reg + ADDR_W'(1);
                    state_next = ST_LEFT_RD;
                end
                else
                begin
                    st_we      = 1'b1;
                    st_waddr   = h_reg;
                    st_wdata   = store_rdata_reg;
                    state_next = ST_RIGHT_RD;
                end
            end
            ST_PLACE:
            begin
                st_we    = 1'b1;
                st_waddr = l_reg;
                st_wdata = pivot_reg;
                if (push_lo_ok)
                begin
                    stk_we    = 1'b1;
                    stk_waddr = sp_reg[STACK_AW-1:0];
                    stk_wdata = '{lo: lo_reg, hi: l_reg - ADDR_W'(1)};
                    sp_next   = sp_inc;
                end
                state_next = ST_PUSH_HI;
            end
            ST_PUSH_HI:
            begin
                if (push_hi_ok)
                begin
                    stk_we     = 1'b1;
                    stk_waddr  = sp_reg[STACK_AW-1:0];
                    stk_wdata  = '{lo: l_reg + ADDR_W'(1), hi: hi_reg};
                    sp_next    = sp_inc;
                    state_next = ST_POP;
                end
                else if (sp_reg != '0)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    k_next     = '0;
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD:
            begin
                st_raddr   = k_reg;
                state_next = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                out_valid_next = 1'b1;
                out_value_next = store_rdata_reg;
                out_last_next  = emit_last;
                out_ovf_next   = ovf_reg;
                state_next     = ST_EMIT_HOLD;
            end
            ST_EMIT_HOLD:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        count_next = '0;
                        sp_next    = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        // fetch the next word while this one leaves
                        k_next     = k_reg + ADDR_W'(1);
                        st_raddr   = k_reg + ADDR_W'(1);
                        state_next = ST_EMIT_WAIT;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            sp_reg        <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            l_reg         <= '0;
            h_reg         <= '0;
            k_reg         <= '0;
            pivot_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_last_reg  <= 1'b0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            sp_reg        <= sp_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            l_reg         <= l_next;
            h_reg         <= h_next;
            k_reg         <= k_next;
            pivot_reg     <= pivot_next;
            out_valid_reg <= out_valid_next;
            out_value_reg <= out_value_next;
            out_last_reg  <= out_last_next;
            out_ovf_reg   <= out_ovf_next;
        end
    end

    // A read that meets a write on one entry returns the old word; no state uses such a read,
    // so no bypass is needed.
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_mem[st_waddr] <= st_wdata;
        end
        store_rdata_reg <= store_mem[st_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        stack_rdata_reg <= stack_mem[stk_raddr];
    end

    assign in_stall     = (state_reg != ST_LOAD);
    assign out_valid    = out_valid_reg;
    assign sorted_value = out_value_reg;
    assign last_result  = out_last_reg;
    assign overflowed   = out_ovf_reg;

`ifndef SYNTHESIS
    // input side open only while no result is pending
    a_load_no_output: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !out_valid)
        else $error("input accepted while a result is pending");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ELEMENTS))
        else $error("element count beyond store depth");

    // scans stay ordered and inside the current range
    a_scan_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RIGHT_CMP || state_reg == ST_LEFT_CMP)
            |-> (l_reg < h_reg) && (lo_reg <= l_reg) && (h_reg <= hi_reg))
        else $error("partition scan out of range");

    // a finished set returns to loading with an empty stack and cleared count
    a_set_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last_result)
            |=> (count_reg == '0) && (sp_reg == '0) && !ovf_reg && !in_stall)
        else $error("state not cleared after the final word");
`endif

endmodule

// ===== bench/tb_quicksort_engine.sv =====
// Testbench for quicksort_engine: random word sets, sorted-order prediction and checks.
module tb_quicksort_engine;

    import qs_pkg::*;

    typedef logic signed [DATA_W-1:0] word_t;

    typedef struct {
        word_t val;
        logic  last;
        logic  drain;   // hold this word back until every sorted word has come out
    } load_word_t;

    typedef struct {
        word_t val;
        logic  last;
        logic  ovf;
    } sorted_word_t;

    localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    localparam int STYLE_RANDOM = 0;
    localparam int STYLE_ASCEND = 1;
    localparam int STYLE_DESCEND = 2;
    localparam int STYLE_EQUAL = 3;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_stall;
    word_t value = '0;
    logic  last_item = 1'b0;
    logic  out_valid;
    logic  out_stall = 1'b0;
    word_t sorted_value;
    logic  last_result;
    logic  overflowed;

    load_word_t   load_q[$];
    sorted_word_t sorted_expect_q[$];
    word_t        set_words[$];
    logic         set_overflow = 1'b0;
    sorted_word_t head;
    int           error_count = 0;
    int           load_total = 0;
    int           burst_left = 1;
    int           gap_left = 0;
    int           stall_mode = 0;
    int           stall_span = 0;

    quicksort_engine i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .value        (value),
        .last_item    (last_item),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sorted_value (sorted_value),
        .last_result  (last_result),
        .overflowed   (overflowed)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Collect one accepted word; on the last one of a set, queue the set in ascending order.
    task automatic sort_words(input word_t w, input logic is_last);
        word_t        ordered[$];
        word_t        key;
        int           j;
        sorted_word_t r;
        if (set_words.size() < MAX_ELEMENTS)
            set_words.push_back(w);
        else
            set_overflow = 1'b1;
        if (!is_last)
            return;
        ordered = set_words;
        for (int i = 1; i < ordered.size(); i++)
        begin
            key = ordered[i];
            j = i - 1;
            while (j >= 0 && ordered[j] > key)
            begin
                ordered[j+1] = ordered[j];
                j--;
            end
            ordered[j+1] = key;
        end
        for (int k = 0; k < ordered.size(); k++)
        begin
            r.val = ordered[k];
            r.last = (k == ordered.size() - 1);
            r.ovf = set_overflow;
            sorted_expect_q.push_back(r);
        end
        set_words.delete();
        set_overflow = 1'b0;
    endtask

    function automatic word_t rand_word();
        case ($urandom_range(0, 5))
            0:       return word_t'($urandom_range(0, 16)) - 8;   // dense, many duplicates
            1:       return ($urandom_range(0, 1) != 0) ? WORD_MAX - $urandom_range(0, 2)
                                                       : WORD_MIN + $urandom_range(0, 2);
            default: return word_t'($urandom);
        endcase
    endfunction

    task automatic add_word(input word_t w, input logic is_last, input logic drain);
        load_word_t lw;
        lw.val = w;
        lw.last = is_last;
        lw.drain = drain;
        load_q.push_back(lw);
        load_total++;
    endtask

    task automatic add_set(input int n, input int style, input logic drain);
        word_t base;
        base = rand_word();
        for (int i = 0; i < n; i++)
        begin
            case (style)
                STYLE_ASCEND:  add_word(base + i, i == n - 1, drain && i == 0);
                STYLE_DESCEND: add_word(base - i, i == n - 1, drain && i == 0);
                STYLE_EQUAL:   add_word(base, i == n - 1, drain && i == 0);
                default:       add_word(rand_word(), i == n - 1, drain && i == 0);
            endcase
        end
    endtask

    // Sender: bursts of words with random gaps; a drain word waits for the output to empty.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sort_words(value, last_item);
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (load_q.size() == 0 || (load_q[0].drain && sorted_expect_q.size() != 0))
                begin
                    in_valid <= 1'b0;
                end
                else
                begin
                    value <= load_q[0].val;
                    last_item <= load_q[0].last;
                    in_valid <= 1'b1;
                    load_q.delete(0);
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // Receiver: stall pattern switches between open, random, mostly stalled and long runs.
    always @(posedge clk)
    begin
        if (stall_span <= 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(10, 60);
        end
        stall_span--;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= $urandom_range(0, 1);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= stall_span[3];
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (sorted_expect_q.size() == 0)
            begin
                $display("%0t: unexpected word: expected none, actual %0d", $time, sorted_value);
                error_count++;
            end
            else
            begin
                head = sorted_expect_q.pop_front();
                if (sorted_value !== head.val)
                begin
                    $display("%0t: sorted_value expected %0d actual %0d",
                             $time, head.val, sorted_value);
                    error_count++;
                end
                if (last_result !== head.last)
                begin
                    $display("%0t: last_result expected %0b actual %0b",
                             $time, head.last, last_result);
                    error_count++;
                end
                if (overflowed !== head.ovf)
                begin
                    $display("%0t: overflowed expected %0b actual %0b",
                             $time, head.ovf, overflowed);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        // directed: single words, extremes, two words, worst-case order, duplicates
        add_word(WORD_MAX, 1'b1, 1'b0);
        add_word(WORD_MIN, 1'b1, 1'b0);
        add_word(WORD_MAX, 1'b0, 1'b0);
        add_word(WORD_MIN, 1'b1, 1'b0);
        add_word(0, 1'b0, 1'b0);
        add_word(-1, 1'b0, 1'b0);
        add_word(1, 1'b0, 1'b0);
        add_word(WORD_MIN, 1'b0, 1'b0);
        add_word(WORD_MAX, 1'b0, 1'b0);
        add_word(WORD_MIN + 1, 1'b1, 1'b0);
        add_set(8, STYLE_DESCEND, 1'b1);
        add_set(4, STYLE_EQUAL, 1'b0);
        add_set(3, STYLE_ASCEND, 1'b0);

        // store full: exactly full, last word dropped, several dropped
        add_set(MAX_ELEMENTS, STYLE_RANDOM, 1'b1);
        add_set(MAX_ELEMENTS + 1, STYLE_RANDOM, 1'b0);
        add_set(MAX_ELEMENTS + 8, STYLE_DESCEND, 1'b0);

        while (load_total < 500)
        begin
            if ($urandom_range(0, 9) == 0)
                add_set($urandom_range(30, MAX_ELEMENTS + 4), $urandom_range(0, 3),
                        $urandom_range(0, 5) == 0);
            else
                add_set($urandom_range(1, 16),
                        ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : STYLE_RANDOM,
                        $urandom_range(0, 5) == 0);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (load_q.size() != 0 || in_valid || sorted_expect_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        if (error_count == 0)
            $display("[quicksort_engine] OK");
        else
            $display("[quicksort_engine] ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("[quicksort_engine] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
src/qs_pkg.sv
src/quicksort_engine.sv
bench/tb_quicksort_engine.sv
